/* src/rnsp_pkg.sv */
// ----------------------------------------------------------------------------
// rnsp_pkg
// Shared types, codes and sizes for the node search / ping power ramp block.
// ----------------------------------------------------------------------------
package rnsp_pkg;

  localparam int NODE_COUNT = 32;
  localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_WAIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_PWR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_PWR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_RSSI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_OFFSET  = 3'd4;

  // operation codes
  localparam logic [2:0] OP_START_SEARCH = 3'd0;
  localparam logic [2:0] OP_START_PING   = 3'd1;
  localparam logic [2:0] OP_TICK         = 3'd2;
  localparam logic [2:0] OP_REPLY        = 3'd3;
  localparam logic [2:0] OP_SET_COMMAND  = 3'd4;

  typedef logic [NODE_W-1:0] node_idx_t;

  typedef struct packed {
    logic [15:0]        reply_wait_ticks;
    logic [7:0]         lowest_power_level;
    logic [7:0]         highest_power_level;
    logic signed [7:0]  desired_rssi_dbm;
    logic [7:0]         node_address_offset;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [4:0]         node_index;
    logic [7:0]         command_byte;
    logic [7:0]         reply_power_level;
    logic signed [7:0]  reply_rssi_dbm;
  } in_item_t;

  typedef struct packed {
    logic       transmit;
    logic [7:0] tx_address;
    logic [7:0] tx_power_level;
    logic [7:0] tx_command;
    logic       radio_to_idle;
    logic       finished;
    logic [4:0] finished_index;
    logic       finished_online;
    logic       busy_res;
  } res_t;

  // node table write requests, one port per store
  typedef struct packed {
    logic       pwr_we;
    node_idx_t  pwr_idx;
    logic [7:0] pwr_val;
    logic       onl_we;
    node_idx_t  onl_idx;
    logic       onl_val;
    logic       cmd_we;
    node_idx_t  cmd_idx;
    logic [7:0] cmd_val;
  } tbl_wr_t;

endpackage

/* src/rnsp_if.sv */
// ----------------------------------------------------------------------------
// rnsp_in_if / rnsp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rnsp_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [4:0]        node_index;
  logic [7:0]        command_byte;
  logic [7:0]        reply_power_level;
  logic signed [7:0] reply_rssi_dbm;

  modport source (output valid, output operation, output node_index, output command_byte,
                  output reply_power_level, output reply_rssi_dbm, input ready);
  modport sink   (input valid, input operation, input node_index, input command_byte,
                  input reply_power_level, input reply_rssi_dbm, output ready);
endinterface

interface rnsp_out_if;
  logic       valid;
  logic       ready;
  logic       transmit;
  logic [7:0] tx_address;
  logic [7:0] tx_power_level;
  logic [7:0] tx_command;
  logic       radio_to_idle;
  logic       finished;
  logic [4:0] finished_index;
  logic       finished_online;
  logic       busy_res;

  modport source (output valid, output transmit, output tx_address, output tx_power_level,
                  output tx_command, output radio_to_idle, output finished,
                  output finished_index, output finished_online, output busy_res,
                  input ready);
  modport sink   (input valid, input transmit, input tx_address, input tx_power_level,
                  input tx_command, input radio_to_idle, input finished,
                  input finished_index, input finished_online, input busy_res,
                  output ready);
endinterface

/* src/rnsp_node_table.sv */
// ----------------------------------------------------------------------------
// rnsp_node_table
// Per-node power level, online mark and command byte storage.
// ----------------------------------------------------------------------------
module rnsp_node_table (
  input  logic              clk,
  input  logic              rst_n,
  input  rnsp_pkg::tbl_wr_t wr,
  input  rnsp_pkg::node_idx_t cur_idx,
  input  rnsp_pkg::node_idx_t cmd_idx,
  output logic [7:0]        cur_power,
  output logic              cur_online,
  output logic [7:0]        cmd_data
);
  import rnsp_pkg::*;

  logic [7:0] pwr_r [NODE_COUNT];
  logic       onl_r [NODE_COUNT];
  logic [7:0] cmd_r [NODE_COUNT];

  // power has no defined reset value
  always_ff @(posedge clk) begin
    if (wr.pwr_we) begin
      pwr_r[wr.pwr_idx] <= wr.pwr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        onl_r[i] <= 1'b0;
        cmd_r[i] <= 8'd0;
      end
    end else begin
      if (wr.onl_we) begin
        onl_r[wr.onl_idx] <= wr.onl_val;
      end
      if (wr.cmd_we) begin
        cmd_r[wr.cmd_idx] <= wr.cmd_val;
      end
    end
  end

  assign cur_power  = pwr_r[cur_idx];
  assign cur_online = onl_r[cur_idx];
  assign cmd_data   = cmd_r[cmd_idx];

endmodule

/* src/rnsp_exchange.sv */
// ----------------------------------------------------------------------------
// rnsp_exchange
// Search / ping sequencer: exchange state, power update and result forming.
// ----------------------------------------------------------------------------
module rnsp_exchange (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rnsp_pkg::in_item_t   item,
  input  rnsp_pkg::cfg_t       cfg,
  input  logic [7:0]           cur_power,
  input  logic                 cur_online,
  input  logic [7:0]           cmd_data,
  output rnsp_pkg::node_idx_t  cur_idx,
  output rnsp_pkg::node_idx_t  cmd_idx,
  output rnsp_pkg::tbl_wr_t    wr,
  output rnsp_pkg::res_t       res
);
  import rnsp_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_PING   = 2'd2;

  logic [1:0]  mode_r,  mode_nxt;
  logic        await_r, await_nxt;
  node_idx_t   cur_r,   cur_nxt;
  logic [15:0] wait_r,  wait_nxt;
  logic [7:0]  addr_r,  addr_nxt;
  logic [7:0]  tcmd_r,  tcmd_nxt;

  logic              idx_ok;
  node_idx_t         idx_n;
  logic signed [9:0] dlt;
  logic signed [9:0] quo;
  logic signed [9:0] np;
  logic [7:0]        new_pwr;
  logic [15:0]       wait_inc;
  logic              elapsed;
  logic              fin;

  assign idx_ok  = 32'(item.node_index) < 32'(NODE_COUNT);
  assign idx_n   = NODE_W'(item.node_index);
  assign cur_idx = cur_r;
  assign cmd_idx = idx_n;

  // power from the reply: level + (desired - measured) / 4, toward zero, clamped to lowest/highest
  always_comb begin
    dlt = {{2{cfg.desired_rssi_dbm[7]}}, cfg.desired_rssi_dbm}
        - {{2{item.reply_rssi_dbm[7]}}, item.reply_rssi_dbm};
    quo = dlt[9] ? ((dlt + 10'sd3) >>> 2) : (dlt >>> 2);
    np  = $signed({2'b00, item.reply_power_level}) + quo;
    priority if (np > $signed({2'b00, cfg.highest_power_level})) begin
      new_pwr = cfg.highest_power_level;
    end else if (np < $signed({2'b00, cfg.lowest_power_level})) begin
      new_pwr = cfg.lowest_power_level;
    end else begin
      new_pwr = np[7:0];
    end
  end

  assign wait_inc = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  assign elapsed  = wait_inc >= cfg.reply_wait_ticks;

  always_comb begin
    mode_nxt  = mode_r;
    await_nxt = await_r;
    cur_nxt   = cur_r;
    wait_nxt  = wait_r;
    addr_nxt  = addr_r;
    tcmd_nxt  = tcmd_r;
    wr        = '0;
    res       = '0;
    fin       = 1'b0;

    if ((item.operation == OP_START_SEARCH || item.operation == OP_START_PING)
        && idx_ok) begin
      cur_nxt    = idx_n;
      mode_nxt   = (item.operation == OP_START_SEARCH) ? MODE_SEARCH : MODE_PING;
      await_nxt  = 1'b0;
      wait_nxt   = 16'd0;
      addr_nxt   = {3'b000, item.node_index} + cfg.node_address_offset;
      tcmd_nxt   = cmd_data;
      wr.onl_we  = 1'b1;
      wr.onl_idx = idx_n;
      wr.onl_val = 1'b0;
      if (item.operation == OP_START_SEARCH) begin
        wr.pwr_we  = 1'b1;
        wr.pwr_idx = idx_n;
        wr.pwr_val = cfg.lowest_power_level;
      end
    end else if (item.operation == OP_SET_COMMAND && idx_ok) begin
      wr.cmd_we  = 1'b1;
      wr.cmd_idx = idx_n;
      wr.cmd_val = item.command_byte;
    end else if (item.operation == OP_REPLY) begin
      wr.pwr_we  = 1'b1;
      wr.pwr_idx = cur_r;
      wr.pwr_val = new_pwr;
      wr.onl_we  = 1'b1;
      wr.onl_idx = cur_r;
      wr.onl_val = 1'b1;
    end else if (item.operation == OP_TICK && mode_r != MODE_IDLE) begin
      if (!await_r) begin
        res.transmit       = 1'b1;
        res.tx_address     = addr_r;
        res.tx_power_level = cur_power;
        res.tx_command     = tcmd_r;
        await_nxt          = 1'b1;
        wait_nxt           = 16'd0;
      end else begin
        wait_nxt = wait_inc;
        if (mode_r == MODE_PING) begin
          if (cur_online || elapsed) begin
            res.radio_to_idle = 1'b1;
            fin               = 1'b1;
          end
        end else if (cur_online) begin
          fin = 1'b1;
        end else if (elapsed) begin
          res.radio_to_idle = 1'b1;
          if (cur_power >= cfg.highest_power_level) begin
            fin = 1'b1;
          end else begin
            // step up one level and transmit again on the next tick
            wr.pwr_we  = 1'b1;
            wr.pwr_idx = cur_r;
            wr.pwr_val = cur_power + 8'd1;
            await_nxt  = 1'b0;
          end
        end
        if (fin) begin
          mode_nxt            = MODE_IDLE;
          res.finished        = 1'b1;
          res.finished_index  = 5'(cur_r);
          res.finished_online = cur_online;
        end
      end
    end

    res.busy_res = mode_nxt != MODE_IDLE;

    // hold everything when no transaction advances
    if (!step) begin
      wr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      await_r <= 1'b0;
      cur_r   <= '0;
      wait_r  <= 16'd0;
      addr_r  <= 8'd0;
      tcmd_r  <= 8'd0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      await_r <= await_nxt;
      cur_r   <= cur_nxt;
      wait_r  <= wait_nxt;
      addr_r  <= addr_nxt;
      tcmd_r  <= tcmd_nxt;
    end
  end

  a_tx_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.transmit |=> await_r && wait_r == 16'd0)
    else $error("transmit did not arm the reply wait");

  a_fin_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.finished |=> mode_r == MODE_IDLE)
    else $error("exchange still active after finishing");

  a_tx_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(res.transmit && res.finished))
    else $error("transmit and finish in the same transaction");

  a_idle_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_r == MODE_IDLE |-> !res.transmit && !res.finished)
    else $error("idle exchange produced activity");

endmodule

/* src/radio_node_search_ping_power_ramp_core.sv */
// ----------------------------------------------------------------------------
// radio_node_search_ping_power_ramp_core
// Hub-side poll exchange controller with per-node power ramping.
//
//   channel  dir  handshake      contents
//   in_ch    in   valid/ready    operation, node index, command, reply level/RSSI
//   out_ch   out  valid/ready    transmit request, finish report, busy
//   cfg_*    in   write enable   register index and write data, no read-back
//
// One transaction per cycle unless out_ch stalls; a taken input passes the input
// register and node table lookup into the result register that out_ch offers.
// The input side stays ready while the result register drains or is being taken.
// Reset is synchronous: exchange state, online marks and commands clear at once.
// A stalled out_ch holds its result and backs up into in_ch.ready.
// ----------------------------------------------------------------------------
module radio_node_search_ping_power_ramp_core (
  input  logic                                clk,
  input  logic                                rst_n,
  rnsp_in_if.sink                             in_ch,
  rnsp_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rnsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rnsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rnsp_pkg::*;

  cfg_t     cfg_r;
  in_item_t in_q_r;
  logic     in_vld_r;
  res_t     out_q_r;
  logic     out_vld_r;

  logic      advance;
  res_t      res;
  tbl_wr_t   wr;
  node_idx_t cur_idx;
  node_idx_t cmd_idx;
  logic [7:0] cur_power;
  logic       cur_online;
  logic [7:0] cmd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_wait_ticks    <= 16'd100;
      cfg_r.lowest_power_level  <= 8'd0;
      cfg_r.highest_power_level <= 8'd15;
      cfg_r.desired_rssi_dbm    <= -8'sd80;
      cfg_r.node_address_offset <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLY_WAIT:   cfg_r.reply_wait_ticks    <= cfg_wdata;
        CFG_LOWEST_PWR:   cfg_r.lowest_power_level  <= cfg_wdata[7:0];
        CFG_HIGHEST_PWR:  cfg_r.highest_power_level <= cfg_wdata[7:0];
        CFG_DESIRED_RSSI: cfg_r.desired_rssi_dbm    <= cfg_wdata[7:0];
        CFG_ADDR_OFFSET:  cfg_r.node_address_offset <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // process the held transaction when the result register has room
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q_r.operation         <= in_ch.operation;
      in_q_r.node_index        <= in_ch.node_index;
      in_q_r.command_byte      <= in_ch.command_byte;
      in_q_r.reply_power_level <= in_ch.reply_power_level;
      in_q_r.reply_rssi_dbm    <= in_ch.reply_rssi_dbm;
    end
  end

  rnsp_node_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .cur_idx    (cur_idx),
    .cmd_idx    (cmd_idx),
    .cur_power  (cur_power),
    .cur_online (cur_online),
    .cmd_data   (cmd_data)
  );

  rnsp_exchange u_exchange (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (in_q_r),
    .cfg        (cfg_r),
    .cur_power  (cur_power),
    .cur_online (cur_online),
    .cmd_data   (cmd_data),
    .cur_idx    (cur_idx),
    .cmd_idx    (cmd_idx),
    .wr         (wr),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.transmit        = out_q_r.transmit;
  assign out_ch.tx_address      = out_q_r.tx_address;
  assign out_ch.tx_power_level  = out_q_r.tx_power_level;
  assign out_ch.tx_command      = out_q_r.tx_command;
  assign out_ch.radio_to_idle   = out_q_r.radio_to_idle;
  assign out_ch.finished        = out_q_r.finished;
  assign out_ch.finished_index  = out_q_r.finished_index;
  assign out_ch.finished_online = out_q_r.finished_online;
  assign out_ch.busy_res        = out_q_r.busy_res;

  a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_q_r.finished |-> !out_q_r.busy_res)
    else $error("finished exchange still reported busy");

  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_q_r.transmit |-> out_q_r.busy_res)
    else $error("transmit without an active exchange");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_q_r))
    else $error("held input transaction lost while stalled");

endmodule
